// ===== sv/plt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and codes for the piecewise linear table lookup block.
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam int KIND_W    = 2;
  localparam int ENTRY_W   = 5;
  localparam int COUNT_W   = 5;
  localparam int REG_IDX_W = 2;
  localparam int FRAC_W    = 16;

  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_Y_FROM_X = 2'd1;
  localparam logic [KIND_W-1:0] KIND_X_FROM_Y = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_X_LEFT    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_X_RIGHT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INTERVALS = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FWD,
    ST_CLAMP,
    ST_FWD_GO,
    ST_FWD_DIV,
    ST_FWD_RD0,
    ST_FWD_RD1,
    ST_FWD_MUL,
    ST_FWD_SUM,
    ST_INV_INIT,
    ST_INV_TEST,
    ST_INV_CMP,
    ST_INV_RDH,
    ST_INV_RDL,
    ST_INV_DIV,
    ST_INV_FIN,
    ST_INV_GO,
    ST_INV_DIV2,
    ST_INV_SUM,
    ST_CHK_INIT,
    ST_CHK_PREV,
    ST_CHK_NEXT,
    ST_DONE
  } state_t;

endpackage

// ===== sv/plt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module plt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/plt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plt_div #(
  parameter int NUM_W = 54,
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   rem;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_next;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] qn;
  logic             qbit;

  always_comb begin
    rem_sh   = {rem[DEN_W-1:0], qn[NUM_W-1]};
    qbit     = rem_sh >= {1'b0, den_r};
    rem_next = qbit ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // numerator shifts out the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      qn    <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      qn  <= {qn[NUM_W-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign quot = qn;

endmodule

// ===== sv/piecewise_linear_table_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_lookup
// Uniform-grid Q16.16 lookup table: entry write, forward and inverse
// interpolation, and table check.
// ----------------------------------------------------------------------------
// channel  | handshake              | payload
// ---------+------------------------+-------------------------------------
// in       | in_valid / in_ready    | kind, entry_index, entry_value, query
// out      | out_valid / out_ready  | answer, table_ok, fault
// cfg      | cfg_write              | cfg_index, cfg_data
//
// One transaction at a time. Forward: one pass of the bit-serial divider,
// whose numerator is VALUE_WIDTH + log2(MAX_INTERVALS+1) + 17 bits wide.
// Inverse: a binary search over the table RAM (one read per step) and up
// to two divider passes. Reset clears control and the grid registers only;
// table contents are undefined until written. A stalled output holds the
// machine in its final state; the next input waits until it is loaded.
// ----------------------------------------------------------------------------
module piecewise_linear_table_lookup #(
  parameter int MAX_INTERVALS = 31,
  parameter int VALUE_WIDTH   = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [plt_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [VALUE_WIDTH-1:0]          cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [plt_pkg::KIND_W-1:0]      kind,
  input  logic [plt_pkg::ENTRY_W-1:0]     entry_index,
  input  logic signed [VALUE_WIDTH-1:0]   entry_value,
  input  logic signed [VALUE_WIDTH-1:0]   query,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [VALUE_WIDTH-1:0]   answer,
  output logic                            table_ok,
  output logic                            fault
);

  import plt_pkg::*;

  localparam int W     = VALUE_WIDTH;
  localparam int WX    = W + 1;
  localparam int DEPTH = MAX_INTERVALS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = AW + 2;
  localparam int PW    = WX + AW + FRAC_W;

  localparam logic signed [SW-1:0]  S_ONE = SW'(1);
  localparam logic signed [W+1:0]   SAT_HI = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [W+1:0]   SAT_LO = {3'b111, {(W-1){1'b0}}};

  state_t state;
  state_t state_next;

  logic signed [W-1:0]  x_left;
  logic signed [W-1:0]  x_right;
  logic [COUNT_W-1:0]   interval_count;

  logic signed [W-1:0]  query_r;
  logic signed [W-1:0]  e0;
  logic signed [W-1:0]  ans;
  logic                 ok_r;
  logic                 fault_r;
  logic signed [SW-1:0] low;
  logic signed [SW-1:0] high;
  logic signed [SW-1:0] mid_r;
  logic [AW+FRAC_W-1:0] p_r;
  logic [PW-1:0]        prod;
  logic                 neg;
  logic [AW-1:0]        ci;

  logic                 in_fire;
  logic                 out_load;
  logic [AW-1:0]        n_eff;
  logic [AW+COUNT_W-1:0] cnt_ext;
  logic [AW+ENTRY_W-1:0] ent_ext;
  logic                 ent_ok;

  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [W-1:0]         mem_rdata;
  logic signed [W-1:0]  rd;

  logic                 div_start;
  logic                 div_done;
  logic [PW-1:0]        div_num;
  logic [WX-1:0]        div_den;
  logic [PW-1:0]        div_quot;

  logic signed [WX-1:0] d_fwd;
  logic [WX-1:0]        d_fwd_mag;
  logic [WX+AW-1:0]     fwd_mul;
  logic signed [WX-1:0] span_x;
  logic [WX-1:0]        span_x_mag;
  logic signed [WX-1:0] diff_rd;
  logic [WX-1:0]        diff_rd_mag;
  logic [WX+FRAC_W-1:0] frac_mul;
  logic signed [WX-1:0] ydiff;
  logic signed [SW-1:0] mid_c;
  logic                 x_le;
  logic                 x_ge;
  logic                 srch_over;
  logic                 low_past;
  logic signed [W+1:0]  sum_base;
  logic [WX-1:0]        sum_mag;
  logic signed [W+1:0]  sum_off;
  logic signed [W+1:0]  sum_raw;
  logic signed [W-1:0]  sum_sat;

  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);
  assign rd       = $signed(mem_rdata);

  always_comb begin
    cnt_ext = {{AW{1'b0}}, interval_count};
    n_eff   = (int'(interval_count) > MAX_INTERVALS) ? AW'(MAX_INTERVALS)
                                                     : cnt_ext[AW-1:0];
    ent_ext = {{AW{1'b0}}, entry_index};
    ent_ok  = int'(entry_index) <= MAX_INTERVALS;
  end

  always_comb begin
    d_fwd       = $signed({query_r[W-1], query_r}) - $signed({x_left[W-1], x_left});
    d_fwd_mag   = d_fwd[WX-1] ? (~d_fwd + 1'b1) : d_fwd;
    fwd_mul     = d_fwd_mag * n_eff;
    span_x      = $signed({x_right[W-1], x_right}) - $signed({x_left[W-1], x_left});
    span_x_mag  = span_x[WX-1] ? (~span_x + 1'b1) : span_x;
    diff_rd     = $signed({rd[W-1], rd}) - $signed({e0[W-1], e0});
    diff_rd_mag = diff_rd[WX-1] ? (~diff_rd + 1'b1) : diff_rd;
    frac_mul    = diff_rd_mag * p_r[FRAC_W-1:0];
    ydiff       = $signed({query_r[W-1], query_r}) - $signed({e0[W-1], e0});
    mid_c       = low + ((high - low) >>> 1);
    x_le        = query_r <= x_left;
    x_ge        = query_r >= x_right;
    srch_over   = low > high;
    low_past    = low > $signed({2'b00, n_eff});
  end

  // shared add and saturate for the final answer
  always_comb begin
    if (state == ST_FWD_SUM) begin
      sum_base = {{2{e0[W-1]}}, e0};
      sum_mag  = prod[WX+FRAC_W-1:FRAC_W];
    end else begin
      sum_base = {{2{x_left[W-1]}}, x_left};
      sum_mag  = div_quot[WX-1:0];
    end
    sum_off = neg ? -$signed({1'b0, sum_mag}) : $signed({1'b0, sum_mag});
    sum_raw = sum_base + sum_off;
    if (sum_raw > SAT_HI) begin
      sum_sat = SAT_HI[W-1:0];
    end else if (sum_raw < SAT_LO) begin
      sum_sat = SAT_LO[W-1:0];
    end else begin
      sum_sat = sum_raw[W-1:0];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      x_left         <= '0;
      x_right        <= W'(65536);
      interval_count <= COUNT_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_X_LEFT:    x_left         <= cfg_data;
        REG_X_RIGHT:   x_right        <= cfg_data;
        REG_INTERVALS: interval_count <= cfg_data[COUNT_W-1:0];
        default:       ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (kind)
            KIND_WRITE:    state_next = ST_DONE;
            KIND_Y_FROM_X: state_next = ST_FWD;
            KIND_X_FROM_Y: state_next = ST_INV_INIT;
            KIND_CHECK:    state_next = ST_CHK_INIT;
            default:       state_next = ST_DONE;
          endcase
        end
      end
      ST_FWD:      state_next = (x_le || x_ge) ? ST_CLAMP : ST_FWD_GO;
      ST_CLAMP:    state_next = ST_DONE;
      ST_FWD_GO:   state_next = ST_FWD_DIV;
      ST_FWD_DIV:  state_next = div_done ? ST_FWD_RD0 : ST_FWD_DIV;
      ST_FWD_RD0:  state_next = ST_FWD_RD1;
      ST_FWD_RD1:  state_next = ST_FWD_MUL;
      ST_FWD_MUL:  state_next = ST_FWD_SUM;
      ST_FWD_SUM:  state_next = ST_DONE;
      ST_INV_INIT: state_next = ST_INV_TEST;
      ST_INV_TEST: begin
        if (!srch_over) begin
          state_next = ST_INV_CMP;
        end else if (low_past || high[SW-1]) begin
          state_next = ST_INV_FIN;
        end else begin
          state_next = ST_INV_RDH;
        end
      end
      ST_INV_CMP:  state_next = (rd == query_r) ? ST_INV_FIN : ST_INV_TEST;
      ST_INV_RDH:  state_next = ST_INV_RDL;
      ST_INV_RDL:  state_next = (diff_rd <= 0) ? ST_DONE : ST_INV_DIV;
      ST_INV_DIV:  state_next = div_done ? ST_INV_FIN : ST_INV_DIV;
      ST_INV_FIN:  state_next = (n_eff == '0) ? ST_DONE : ST_INV_GO;
      ST_INV_GO:   state_next = ST_INV_DIV2;
      ST_INV_DIV2: state_next = div_done ? ST_INV_SUM : ST_INV_DIV2;
      ST_INV_SUM:  state_next = ST_DONE;
      ST_CHK_INIT: state_next = ST_CHK_PREV;
      ST_CHK_PREV: state_next = (n_eff == '0) ? ST_DONE : ST_CHK_NEXT;
      ST_CHK_NEXT: state_next = (ci == n_eff) ? ST_DONE : ST_CHK_NEXT;
      ST_DONE:     state_next = out_load ? ST_IDLE : ST_DONE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // control outputs: memory port, divider, input ready
  always_comb begin
    in_ready  = (state == ST_IDLE);
    mem_we    = 1'b0;
    mem_addr  = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state)
      ST_IDLE: begin
        mem_we   = in_fire && (kind == KIND_WRITE) && ent_ok;
        mem_addr = ent_ext[AW-1:0];
      end
      ST_FWD:      mem_addr = x_le ? '0 : n_eff;
      ST_FWD_GO: begin
        div_start = 1'b1;
        div_num   = {prod[WX+AW-1:0], {FRAC_W{1'b0}}};
        div_den   = span_x;
      end
      ST_FWD_RD0:  mem_addr = p_r[AW+FRAC_W-1:FRAC_W];
      ST_FWD_RD1:  mem_addr = p_r[AW+FRAC_W-1:FRAC_W] + AW'(1);
      ST_INV_TEST: mem_addr = srch_over ? high[AW-1:0] : mid_c[AW-1:0];
      ST_INV_RDH:  mem_addr = low[AW-1:0];
      ST_INV_RDL: begin
        div_start = !(diff_rd <= 0);
        div_num   = {{AW{1'b0}}, ydiff, {FRAC_W{1'b0}}};
        div_den   = diff_rd;
      end
      ST_INV_GO: begin
        div_start = 1'b1;
        div_num   = {{FRAC_W{1'b0}}, prod[PW-1:FRAC_W]};
        div_den   = {{(WX-AW){1'b0}}, n_eff};
      end
      ST_CHK_PREV: mem_addr = ci;
      ST_CHK_NEXT: mem_addr = ci + AW'(1);
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          query_r <= query;
          ans     <= '0;
          ok_r    <= 1'b0;
          fault_r <= 1'b0;
        end
      end
      ST_FWD:      prod <= PW'(fwd_mul);
      ST_CLAMP:    ans  <= rd;
      ST_FWD_DIV: begin
        if (div_done) begin
          p_r <= div_quot[AW+FRAC_W-1:0];
        end
      end
      ST_FWD_RD1:  e0 <= rd;
      ST_FWD_MUL: begin
        neg  <= diff_rd[WX-1];
        prod <= PW'(frac_mul);
      end
      ST_FWD_SUM:  ans <= sum_sat;
      ST_INV_INIT: begin
        low  <= '0;
        high <= $signed({2'b00, n_eff});
      end
      ST_INV_TEST: begin
        if (!srch_over) begin
          mid_r <= mid_c;
        end else if (low_past) begin
          p_r <= {n_eff, {FRAC_W{1'b0}}};
        end else if (high[SW-1]) begin
          p_r <= '0;
        end
      end
      ST_INV_CMP: begin
        if (rd > query_r) begin
          high <= mid_r - S_ONE;
        end else if (rd < query_r) begin
          low <= mid_r + S_ONE;
        end else begin
          p_r <= {mid_r[AW-1:0], {FRAC_W{1'b0}}};
        end
      end
      ST_INV_RDH:  e0 <= rd;
      ST_INV_RDL: begin
        if (diff_rd <= 0) begin
          fault_r <= 1'b1;
        end
      end
      ST_INV_DIV: begin
        if (div_done) begin
          p_r <= {high[AW-1:0], div_quot[FRAC_W-1:0]};
        end
      end
      ST_INV_FIN: begin
        if (n_eff == '0) begin
          fault_r <= 1'b1;
        end else begin
          neg  <= span_x[WX-1];
          prod <= span_x_mag * p_r;
        end
      end
      ST_INV_SUM:  ans <= sum_sat;
      ST_CHK_INIT: begin
        ok_r <= x_left < x_right;
        ci   <= AW'(1);
      end
      ST_CHK_PREV: e0 <= rd;
      ST_CHK_NEXT: begin
        if (!(e0 < rd)) begin
          ok_r <= 1'b0;
        end
        e0 <= rd;
        if (ci != n_eff) begin
          ci <= ci + AW'(1);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      answer   <= fault_r ? '0 : ans;
      table_ok <= ok_r;
      fault    <= fault_r;
    end
  end

  plt_ram #(
    .WIDTH (W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (entry_value),
    .rdata (mem_rdata)
  );

  plt_div #(
    .NUM_W (PW),
    .DEN_W (WX)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule

// ===== sim/piecewise_linear_table_lookup_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_lookup_tb
// Drives entry writes, forward and inverse lookups and table checks through
// the valid/ready channels, with random gaps and output stalls, under a
// series of grid settings. A Q16.16 interpolation predictor with its own
// copy of the table and grid supplies the expected answer, table_ok and fault.
// ----------------------------------------------------------------------------
module piecewise_linear_table_lookup_tb;
  import plt_pkg::*;

  typedef struct {
    logic signed [31:0] answer;
    logic               table_ok;
    logic               fault;
  } lookup_result_t;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [ENTRY_W-1:0] idx;
    logic signed [31:0] value;
    logic signed [31:0] qry;
    bit                 typed;
    lookup_result_t     res;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [KIND_W-1:0]    kind;
  logic [ENTRY_W-1:0]   entry_index;
  logic signed [31:0]   entry_value;
  logic signed [31:0]   query;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [31:0]   answer;
  logic                 table_ok;
  logic                 fault;

  // grid and table as the block should hold them
  longint         grid_y[32];
  longint         grid_left;
  longint         grid_right;
  int             grid_n;
  bit             div_fault;
  lookup_result_t pending_results[$];
  int             errors;
  int             results_seen;
  bit             no_gaps;

  piecewise_linear_table_lookup DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .entry_index(entry_index), .entry_value(entry_value), .query(query),
    .out_valid(out_valid), .out_ready(out_ready),
    .answer(answer), .table_ok(table_ok), .fault(fault)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // trunc(a * b / d), exact; zero divisor flags a fault
  function automatic longint scaled_quot(longint a, longint unsigned b, longint unsigned d);
    logic [127:0]    prod;
    logic [127:0]    q;
    longint unsigned ua;
    longint          r;
    if (d == 0) begin
      div_fault = 1'b1;
      return 0;
    end
    ua = (a < 0) ? longint'(-a) : longint'(a);
    prod = {64'd0, ua} * {64'd0, b};
    q = prod / {64'd0, d};
    if (q > 128'h7fff_ffff_ffff_ffff) q = 128'h7fff_ffff_ffff_ffff;
    r = longint'(q[63:0]);
    return (a < 0) ? -r : r;
  endfunction

  function automatic lookup_result_t predict_lookup(logic [KIND_W-1:0] k, int idx,
                                                    longint val, longint x);
    lookup_result_t r;
    longint         a;
    longint         p;
    longint         span;
    int             i;
    int             lo;
    int             hi;
    int             mid;
    bit             ok;
    bit             found;
    a = 0;
    ok = 1'b0;
    div_fault = 1'b0;
    case (k)
      KIND_WRITE: begin
        grid_y[idx] = val;
      end
      KIND_Y_FROM_X: begin
        if (x <= grid_left) a = grid_y[0];
        else if (x >= grid_right) a = grid_y[grid_n];
        else begin
          p = scaled_quot(x - grid_left, longint'(grid_n) << 16, grid_right - grid_left);
          i = int'(p >>> 16);
          if (i >= grid_n) a = grid_y[grid_n];
          else a = sat32(grid_y[i] + scaled_quot(grid_y[i+1] - grid_y[i], p & 'hffff, 65536));
        end
      end
      KIND_X_FROM_Y: begin
        lo = 0;
        hi = grid_n;
        found = 1'b0;
        p = 0;
        while (!found) begin
          if (lo > hi) begin
            if (lo > grid_n) p = longint'(grid_n) << 16;
            else if (hi < 0) p = 0;
            else begin
              span = (grid_y[hi] < grid_y[lo]) ? grid_y[lo] - grid_y[hi] : 0;
              p = (longint'(hi) << 16) + scaled_quot(x - grid_y[hi], 65536, span);
            end
            found = 1'b1;
          end else begin
            mid = lo + (hi - lo) / 2;
            if (grid_y[mid] > x) hi = mid - 1;
            else if (grid_y[mid] < x) lo = mid + 1;
            else begin
              p = longint'(mid) << 16;
              found = 1'b1;
            end
          end
        end
        if (!div_fault)
          a = sat32(grid_left + scaled_quot(grid_right - grid_left, p,
                                            longint'(grid_n) << 16));
      end
      default: begin
        ok = grid_left < grid_right;
        for (i = 0; i < grid_n; i++) ok = ok && (grid_y[i] < grid_y[i+1]);
      end
    endcase
    if (div_fault) a = 0;
    r.answer = a[31:0];
    r.table_ok = ok;
    r.fault = div_fault;
    return r;
  endfunction

  task automatic send_item(logic [KIND_W-1:0] k, int idx, longint val, longint x,
                           bit typed, lookup_result_t typed_res);
    int             gap;
    lookup_result_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind = k;
    entry_index = idx[ENTRY_W-1:0];
    entry_value = val[31:0];
    query = x[31:0];
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    r = predict_lookup(k, idx, val, x);
    if (typed) r = typed_res;
    pending_results.push_back(r);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, longint val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val[31:0];
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_X_LEFT:  grid_left = longint'(signed'(val[31:0]));
      REG_X_RIGHT: grid_right = longint'(signed'(val[31:0]));
      default:     grid_n = int'(val[4:0]);
    endcase
  endtask

  function automatic longint rand32();
    return longint'(signed'($urandom));
  endfunction

  function automatic longint pick_x();
    longint unsigned r;
    int              sel;
    sel = $urandom_range(0, 99);
    r = {$urandom, $urandom};
    if (sel < 45 && grid_left < grid_right)
      return grid_left + longint'(r % longint'(grid_right - grid_left + 1));
    if (sel < 60) return sat32(grid_left + $urandom_range(0, 4) - 2);
    if (sel < 75) return sat32(grid_right + $urandom_range(0, 4) - 2);
    if (sel < 85) return ($urandom_range(0, 1) != 0) ? 64'sd2147483647 : -64'sd2147483648;
    return rand32();
  endfunction

  function automatic longint pick_y();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return grid_y[$urandom_range(0, grid_n)];
    if (sel < 70) return sat32(grid_y[$urandom_range(0, grid_n)] + rand32() / 65536);
    if (sel < 80) return ($urandom_range(0, 1) != 0) ? 64'sd2147483647 : -64'sd2147483648;
    return rand32();
  endfunction

  // ascending entries 0..n so the check can pass
  task automatic fill_ascending();
    longint v;
    longint smax;
    int     i;
    smax = ($urandom_range(0, 1) != 0) ? 64'd4294960000 / (grid_n + 1) : 70000;
    v = -64'sd2147483648 + $urandom_range(0, 1000);
    for (i = 0; i <= grid_n; i++) begin
      send_item(KIND_WRITE, i, v, rand32(), 1'b0, '{default: '0});
      v += 1 + longint'({$urandom, $urandom} % longint'(smax));
    end
  endtask

  // receiver: random stalls, one long hold-off, compare with the oldest expectation
  initial begin
    int             stall;
    bit             held;
    lookup_result_t e;
    out_ready = 1'b0;
    held = 1'b0;
    errors = 0;
    results_seen = 0;
    wait (!rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 14);
      if (!held && results_seen >= 250) begin
        stall = 600;
        held = 1'b1;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: answer %0d", answer);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (answer !== e.answer) begin
          $error("answer: expected %0d, got %0d", e.answer, answer);
          errors++;
        end
        if (table_ok !== e.table_ok) begin
          $error("table_ok: expected %0b, got %0b", e.table_ok, table_ok);
          errors++;
        end
        if (fault !== e.fault) begin
          $error("fault: expected %0b, got %0b", e.fault, fault);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t      rows[$];
    lookup_result_t z;
    longint         ph_left[13];
    longint         ph_right[13];
    int             ph_n[13];
    int             ph;
    int             j;
    int             sel;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = KIND_WRITE;
    entry_index = '0;
    entry_value = '0;
    query = '0;
    no_gaps = 1'b0;
    grid_left = 0;
    grid_right = 65536;
    grid_n = 1;
    foreach (grid_y[i]) grid_y[i] = 0;
    z = '{default: '0};

    rows = '{
      '{KIND_WRITE,    0, 32'sh8000_0000, 0, 1, '{32'sd0, 1'b0, 1'b0}},
      '{KIND_WRITE,    1, 32'sh7fff_ffff, 0, 1, '{32'sd0, 1'b0, 1'b0}},
      '{KIND_Y_FROM_X, 0, 0, 32'sh8000_0000, 1, '{32'sh8000_0000, 1'b0, 1'b0}},
      '{KIND_Y_FROM_X, 0, 0, 32'sh7fff_ffff, 1, '{32'sh7fff_ffff, 1'b0, 1'b0}},
      '{KIND_Y_FROM_X, 0, 0, 32768, 0, '{default: '0}},
      '{KIND_Y_FROM_X, 0, 0, 1, 0, '{default: '0}},
      '{KIND_CHECK,    0, 0, 0, 1, '{32'sd0, 1'b1, 1'b0}},
      '{KIND_X_FROM_Y, 0, 0, 32'sh8000_0000, 1, '{32'sd0, 1'b0, 1'b0}},
      '{KIND_X_FROM_Y, 0, 0, 32'sh7fff_ffff, 1, '{32'sd65536, 1'b0, 1'b0}},
      '{KIND_X_FROM_Y, 0, 0, 0, 0, '{default: '0}},
      '{KIND_WRITE,    1, 32'sh8000_0000, 0, 1, '{32'sd0, 1'b0, 1'b0}},
      '{KIND_CHECK,    0, 0, 0, 1, '{32'sd0, 1'b0, 1'b0}},
      '{KIND_X_FROM_Y, 0, 0, 5, 0, '{default: '0}},
      '{KIND_WRITE,    0, 0, 0, 1, '{32'sd0, 1'b0, 1'b0}},
      '{KIND_WRITE,    1, 65536, 0, 1, '{32'sd0, 1'b0, 1'b0}},
      '{KIND_X_FROM_Y, 0, 0, 100, 0, '{default: '0}},
      '{KIND_Y_FROM_X, 0, 0, 65535, 0, '{default: '0}},
      '{KIND_WRITE,   31, 32'sh5555_5555, 32'shaaaa_aaaa, 1, '{32'sd0, 1'b0, 1'b0}},
      '{KIND_WRITE,   30, 32'shaaaa_aaaa, 32'sh5555_5555, 1, '{32'sd0, 1'b0, 1'b0}}
    };

    ph_left  = '{-655360, -64'sd2147483648, 0, 100, 65536, -64'sd2147483648,
                 0, 0, 0, 0, 0, -1000, 0};
    ph_right = '{655360, 64'sd2147483647, 65536, 100, -65536, 64'sd2147483647,
                 0, 0, 0, 0, 0, 1000, 0};
    ph_n     = '{8, 31, 0, 4, 5, 1, 0, 0, 0, 0, 0, 31, 0};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i])
      send_item(rows[i].kind, rows[i].idx, rows[i].value, rows[i].qry,
                rows[i].typed, rows[i].res);

    // every entry gets written before any wider setting can read it
    for (j = 0; j < 32; j++) send_item(KIND_WRITE, j, rand32(), rand32(), 1'b0, z);

    for (ph = 0; ph < 13; ph++) begin
      wait_idle();
      if (ph >= 6 && ph != 11) begin
        ph_left[ph] = rand32();
        ph_right[ph] = ($urandom_range(0, 3) != 0) ?
                       sat32(ph_left[ph] + $urandom_range(1, 32'h7fff_ffff)) : rand32();
        ph_n[ph] = $urandom_range(0, 31);
      end
      write_reg(REG_X_LEFT, ph_left[ph]);
      write_reg(REG_X_RIGHT, ph_right[ph]);
      write_reg(REG_INTERVALS, ph_n[ph]);
      no_gaps = (ph % 4 == 3);
      if ($urandom_range(0, 2) != 0) fill_ascending();
      for (j = 0; j < 66; j++) begin
        sel = $urandom_range(0, 99);
        if (sel < 10)
          send_item(KIND_WRITE, $urandom_range(0, 31), rand32(), rand32(), 1'b0, z);
        else if (sel < 45)
          send_item(KIND_Y_FROM_X, $urandom_range(0, 31), rand32(), pick_x(), 1'b0, z);
        else if (sel < 85)
          send_item(KIND_X_FROM_Y, $urandom_range(0, 31), rand32(), pick_y(), 1'b0, z);
        else
          send_item(KIND_CHECK, $urandom_range(0, 31), rand32(), rand32(), 1'b0, z);
      end
    end

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/plt_pkg.sv
sv/plt_ram.sv
sv/plt_div.sv
sv/piecewise_linear_table_lookup.sv
sim/piecewise_linear_table_lookup_tb.sv
